// ===== rtl/block_average_to_glyph_macros.svh =====
// Assertion macros shared by the block_average_to_glyph RTL.
`ifndef BLOCK_AVERAGE_TO_GLYPH_MACROS_SVH
`define BLOCK_AVERAGE_TO_GLYPH_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BAG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BAG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bag_pkg.sv =====
// Shared types, constants and the glyph ramp for block_average_to_glyph.
package bag_pkg;

    localparam int COLUMNS_DEF = 120;
    localparam int ROWS_DEF    = 30;

    localparam int PIX_W   = 12;   // pixel position counters
    localparam int CNT_W   = 6;    // position inside a cell, below 64
    localparam int CW_W    = 7;    // cell_width / cell_height registers
    localparam int IW_W    = 13;   // image_width register
    localparam int CFG_W   = 13;   // configuration write data
    localparam int IDX_W   = 2;    // configuration register index
    localparam int CH_W    = 8;    // one colour channel
    localparam int VAL_W   = 10;   // R+G+B of one pixel
    localparam int SUM_W   = 22;   // running cell sum
    localparam int AREA_W  = 13;   // cell_width*cell_height, up to 4096
    localparam int T_W     = 17;   // floor(sum*18/765)
    localparam int OCOL_W  = 7;
    localparam int OROW_W  = 5;
    localparam int LVL_W   = 5;
    localparam int CODE_W  = 7;
    localparam int DATA_W  = 24;

    // floor(n/85) == (n*RECIP_M) >> RECIP_SHIFT for every n below 2^23
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 31;
    localparam logic [RECIP_W-1:0] RECIP_M = 25'd25264514;
    localparam int PROD_W      = 48;

    localparam logic [CW_W-1:0]  CELL_MAX  = 7'd64;
    localparam logic [IW_W-1:0]  IMG_MAX   = 13'd4096;
    localparam logic [LVL_W-1:0] LEVEL_MAX = 5'd16;

    localparam logic [CW_W-1:0]  CELL_W_RST = 7'd5;
    localparam logic [CW_W-1:0]  CELL_H_RST = 7'd16;
    localparam logic [IW_W-1:0]  IMG_W_RST  = 13'd640;

    typedef enum logic [IDX_W-1:0] {
        REG_CELL_WIDTH  = 2'd0,
        REG_CELL_HEIGHT = 2'd1,
        REG_IMAGE_WIDTH = 2'd2
    } cfg_reg_t;

    // Position of the pixel now at the input
    typedef struct packed {
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        logic             first;
        logic             last;
        logic             in_grid;
        logic             frame_last;
    } pos_t;

    // A finished cell on its way to the level unit
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [OCOL_W-1:0] column;
        logic [OROW_W-1:0] row;
        logic              frame_done;
    } cell_t;

    function automatic logic [CODE_W-1:0] glyph_code(input logic [LVL_W-1:0] level);
        logic [CODE_W-1:0] code;
        unique case (level)
            5'd0:    code = 7'd32;   // ' '
            5'd1:    code = 7'd46;   // '.'
            5'd2:    code = 7'd58;   // ':'
            5'd3:    code = 7'd33;   // '!'
            5'd4:    code = 7'd47;   // '/'
            5'd5:    code = 7'd114;  // 'r'
            5'd6:    code = 7'd40;   // '('
            5'd7:    code = 7'd108;  // 'l'
            5'd8:    code = 7'd49;   // '1'
            5'd9:    code = 7'd90;   // 'Z'
            5'd10:   code = 7'd52;   // '4'
            5'd11:   code = 7'd72;   // 'H'
            5'd12:   code = 7'd57;   // '9'
            5'd13:   code = 7'd87;   // 'W'
            5'd14:   code = 7'd56;   // '8'
            5'd15:   code = 7'd36;   // '$'
            default: code = 7'd64;   // '@', also any saturated level
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/block_average_to_glyph.sv =====
// Top level of the block-average to ASCII glyph converter.
// Pixels enter on s_t*, raster order, tuser marking the first pixel of a frame.
// Each pixel is a read-modify-write of one column-sum memory entry (synchronous read,
// forwarding from the previous write), so pixels that finish no cell are taken one per
// clock while the level unit is idle. The bottom-right pixel of a cell finishes it:
// s_tready drops for one cycle while the cell is handed on, then stays low while the
// level unit is busy (reciprocal multiply for /85, saturation check, four restoring divide
// steps, output load; the divide steps are skipped when the level saturates), and longer
// while m_tready holds back the previous result. After reset and after every configuration
// write, three serial dividers re-derive the cell coordinates, during which s_tready stays
// low; configuration writes are always accepted.
module block_average_to_glyph #(
    parameter int COLUMNS = bag_pkg::COLUMNS_DEF,
    parameter int ROWS    = bag_pkg::ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bag_pkg::DATA_W-1:0]  s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic                        s_tuser,   // frame_start
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bag_pkg::DATA_W-1:0]  m_tdata,   // cell_column[6:0], cell_row[11:7],
                                                   // glyph_index[16:12], glyph_code[23:17]
    output logic                        m_tlast,   // frame_done
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bag_pkg::IDX_W-1:0]   cfg_index,
    input  logic [bag_pkg::CFG_W-1:0]   cfg_data
);

    localparam int CW = bag_pkg::CW_W;
    localparam int IW = bag_pkg::IW_W;

    logic [CW-1:0]  cw_reg, ch_reg;
    logic [IW-1:0]  iw_reg;
    logic           cfg_write;
    logic           s_accept;
    logic           pos_ready;
    bag_pkg::pos_t  pos;
    logic           cell_valid;
    bag_pkg::cell_t fin_cell;
    logic           lvl_busy;
    logic [bag_pkg::OCOL_W-1:0] out_column;
    logic [bag_pkg::OROW_W-1:0] out_row;
    logic [bag_pkg::LVL_W-1:0]  out_level;
    logic [bag_pkg::CODE_W-1:0] out_code;

    function automatic logic [CW-1:0] clamp_cell(input logic [CW-1:0] v);
        logic [CW-1:0] r;
        if (v == '0)
            r = CW'(1);
        else if (v > bag_pkg::CELL_MAX)
            r = bag_pkg::CELL_MAX;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [IW-1:0] clamp_image(input logic [IW-1:0] v);
        logic [IW-1:0] r;
        if (v == '0)
            r = IW'(1);
        else if (v > bag_pkg::IMG_MAX)
            r = bag_pkg::IMG_MAX;
        else
            r = v;
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // registers hold the clamped, effective values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= bag_pkg::CELL_W_RST;
            ch_reg <= bag_pkg::CELL_H_RST;
            iw_reg <= bag_pkg::IMG_W_RST;
        end
        else if (cfg_write)
        begin
            unique case (bag_pkg::cfg_reg_t'(cfg_index))
                bag_pkg::REG_CELL_WIDTH:  cw_reg <= clamp_cell(cfg_data[CW-1:0]);
                bag_pkg::REG_CELL_HEIGHT: ch_reg <= clamp_cell(cfg_data[CW-1:0]);
                bag_pkg::REG_IMAGE_WIDTH: iw_reg <= clamp_image(cfg_data[IW-1:0]);
                default:                  ;
            endcase
        end
    end

    assign s_tready = pos_ready && !lvl_busy && !cell_valid;
    assign s_accept = s_tvalid && s_tready;

    bag_pos #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .recalc      (cfg_write),
        .advance     (s_accept),
        .frame_start (s_tuser),
        .cw          (cw_reg),
        .ch          (ch_reg),
        .iw          (iw_reg),
        .ready       (pos_ready),
        .pos         (pos)
    );

    bag_sum #(.COLUMNS(COLUMNS)) u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (s_accept),
        .pos        (pos),
        .red        (s_tdata[7:0]),
        .green      (s_tdata[15:8]),
        .blue       (s_tdata[23:16]),
        .cell_valid (cell_valid),
        .fin_cell   (fin_cell)
    );

    bag_level u_level (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (cell_valid),
        .fin_cell       (fin_cell),
        .cw             (cw_reg),
        .ch             (ch_reg),
        .busy           (lvl_busy),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_column     (out_column),
        .out_row        (out_row),
        .out_level      (out_level),
        .out_code       (out_code),
        .out_frame_done (m_tlast)
    );

    assign m_tdata = {out_code, out_level, out_row, out_column};

endmodule

// ===== rtl/bag_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module bag_div #(
    parameter int NUM_W = 12,
    parameter int DEN_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [STEP_W-1:0] cnt_reg;
    logic [NUM_W-1:0]  quot_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, quot_reg[NUM_W-1]};
        diff  = trial - {1'b0, den};
        ge    = trial >= {1'b0, den};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            cnt_reg  <= STEP_W'(NUM_W);
            quot_reg <= num;
            rem_reg  <= '0;
        end
        else if (cnt_reg != '0)
        begin
            // shift in the next dividend bit, subtract where it fits
            rem_reg  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_reg <= {quot_reg[NUM_W-2:0], ge};
            cnt_reg  <= cnt_reg - STEP_W'(1);
        end
    end

    assign busy = cnt_reg != '0;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/bag_pos.sv =====
// Pixel position tracker: column/row counters and cell coordinates.
module bag_pos #(
    parameter int COLUMNS = bag_pkg::COLUMNS_DEF,
    parameter int ROWS    = bag_pkg::ROWS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       recalc,
    input  logic                       advance,
    input  logic                       frame_start,
    input  logic [bag_pkg::CW_W-1:0]   cw,
    input  logic [bag_pkg::CW_W-1:0]   ch,
    input  logic [bag_pkg::IW_W-1:0]   iw,
    output logic                       ready,
    output bag_pkg::pos_t              pos
);

    localparam int PW     = bag_pkg::PIX_W;
    localparam int NW     = bag_pkg::CNT_W;
    localparam int CW     = bag_pkg::CW_W;
    localparam int IW     = bag_pkg::IW_W;
    localparam int COL_AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [PW-1:0] COLS_P  = PW'(COLUMNS);
    localparam logic [PW-1:0] ROWS_P  = PW'(ROWS);
    localparam logic [PW-1:0] ROWS_M1 = PW'(ROWS - 1);

    typedef enum logic [1:0] {P_START, P_WAIT, P_RUN} pstate_t;

    pstate_t           state_reg;
    logic [PW-1:0]     x_reg, y_reg, col_reg, row_reg;
    logic [NW-1:0]     px_reg, py_reg;
    logic [COL_AW-1:0] lastm1_reg;
    logic              lastok_reg;

    logic [PW-1:0]     eff_x, eff_y, eff_col, eff_row;
    logic [NW-1:0]     eff_px, eff_py;
    logic [PW-1:0]     x_next, y_next, col_next, row_next;
    logic [NW-1:0]     px_next, py_next;
    logic              x_wrap, y_wrap, px_end, py_end;

    logic              div_start, bx, by, bi, div_busy;
    logic [PW-1:0]     qx, qy;
    logic [CW-1:0]     rx, ry;
    logic [IW-1:0]     qi, lc, lc_m1;
    logic [CW-1:0]     ri;

    assign div_start = state_reg == P_START;
    assign div_busy  = bx | by | bi;

    bag_div #(.NUM_W(PW), .DEN_W(CW)) u_div_x (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(x_reg), .den(cw),
        .busy(bx), .quot(qx), .rem(rx)
    );

    bag_div #(.NUM_W(PW), .DEN_W(CW)) u_div_y (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(y_reg), .den(ch),
        .busy(by), .quot(qy), .rem(ry)
    );

    // whole cells across one line
    bag_div #(.NUM_W(IW), .DEN_W(CW)) u_div_i (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(iw), .den(cw),
        .busy(bi), .quot(qi), .rem(ri)
    );

    always_comb
    begin
        lc    = (qi >= IW'(COLUMNS)) ? IW'(COLUMNS) : qi;
        lc_m1 = lc - IW'(1);

        eff_x   = frame_start ? '0 : x_reg;
        eff_y   = frame_start ? '0 : y_reg;
        eff_col = frame_start ? '0 : col_reg;
        eff_row = frame_start ? '0 : row_reg;
        eff_px  = frame_start ? '0 : px_reg;
        eff_py  = frame_start ? '0 : py_reg;

        x_wrap = ({1'b0, eff_x} + IW'(1)) >= iw;
        y_wrap = eff_y == '1;
        px_end = ({1'b0, eff_px} + CW'(1)) == cw;
        py_end = ({1'b0, eff_py} + CW'(1)) == ch;

        pos.col        = eff_col;
        pos.row        = eff_row;
        pos.first      = (eff_px == '0) && (eff_py == '0);
        pos.last       = ({1'b0, eff_px} == cw - CW'(1)) && ({1'b0, eff_py} == ch - CW'(1));
        pos.in_grid    = (eff_col < COLS_P) && (eff_row < ROWS_P);
        pos.frame_last = pos.in_grid && lastok_reg && (eff_row == ROWS_M1)
                         && (eff_col[COL_AW-1:0] == lastm1_reg);

        x_next   = eff_x + PW'(1);
        px_next  = px_end ? '0 : eff_px + NW'(1);
        col_next = px_end ? eff_col + PW'(1) : eff_col;
        y_next   = eff_y;
        py_next  = eff_py;
        row_next = eff_row;
        if (x_wrap)
        begin
            x_next   = '0;
            px_next  = '0;
            col_next = '0;
            y_next   = eff_y + PW'(1);
            if (y_wrap)
            begin
                py_next  = '0;
                row_next = '0;
            end
            else
            begin
                py_next  = py_end ? '0 : eff_py + NW'(1);
                row_next = py_end ? eff_row + PW'(1) : eff_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= P_START;
            x_reg      <= '0;
            y_reg      <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            lastm1_reg <= '0;
            lastok_reg <= 1'b0;
        end
        else if (recalc)
        begin
            state_reg <= P_START;
        end
        else
        begin
            unique case (state_reg)
                P_START:
                begin
                    state_reg <= P_WAIT;
                end
                P_WAIT:
                begin
                    // reload cell coordinates from the current pixel position
                    if (!div_busy)
                    begin
                        col_reg    <= qx;
                        px_reg     <= rx[NW-1:0];
                        row_reg    <= qy;
                        py_reg     <= ry[NW-1:0];
                        lastm1_reg <= lc_m1[COL_AW-1:0];
                        lastok_reg <= lc != '0;
                        state_reg  <= P_RUN;
                    end
                end
                P_RUN:
                begin
                    if (advance)
                    begin
                        x_reg   <= x_next;
                        y_reg   <= y_next;
                        col_reg <= col_next;
                        row_reg <= row_next;
                        px_reg  <= px_next;
                        py_reg  <= py_next;
                    end
                end
                default:
                begin
                    state_reg <= P_START;
                end
            endcase
        end
    end

    assign ready = state_reg == P_RUN;

endmodule

// ===== rtl/bag_sum.sv =====
// Column sum memory with read-modify-write and write forwarding.
`include "block_average_to_glyph_macros.svh"

module bag_sum #(
    parameter int COLUMNS = bag_pkg::COLUMNS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  bag_pkg::pos_t             pos,
    input  logic [bag_pkg::CH_W-1:0]  red,
    input  logic [bag_pkg::CH_W-1:0]  green,
    input  logic [bag_pkg::CH_W-1:0]  blue,
    output logic                      cell_valid,
    output bag_pkg::cell_t            fin_cell
);

    localparam int COL_AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int SW     = bag_pkg::SUM_W;
    localparam int VW     = bag_pkg::VAL_W;

    logic [SW-1:0] mem [COLUMNS];

    logic                       take;
    logic [VW-1:0]              val;
    logic [SW-1:0]              rd_data_reg;
    logic                       b_valid_reg;
    logic                       b_first_reg, b_last_reg, b_fdone_reg;
    logic [COL_AW-1:0]          b_idx_reg;
    logic [bag_pkg::OCOL_W-1:0] b_ocol_reg;
    logic [bag_pkg::OROW_W-1:0] b_orow_reg;
    logic [VW-1:0]              b_val_reg;
    logic                       w_valid_reg;
    logic [COL_AW-1:0]          w_idx_reg;
    logic [SW-1:0]              w_sum_reg;
    logic [SW-1:0]              base, s;

    assign take = advance && pos.in_grid;
    assign val  = VW'(red) + VW'(green) + VW'(blue);

    always_comb
    begin
        // the memory read missed a write to the same column on the same edge
        base = (w_valid_reg && (w_idx_reg == b_idx_reg)) ? w_sum_reg : rd_data_reg;
        s    = b_first_reg ? SW'(b_val_reg) : base + SW'(b_val_reg);
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_data_reg <= mem[pos.col[COL_AW-1:0]];
        end
        if (b_valid_reg)
        begin
            mem[b_idx_reg] <= s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            b_first_reg <= pos.first;
            b_last_reg  <= pos.last;
            b_fdone_reg <= pos.frame_last;
            b_idx_reg   <= pos.col[COL_AW-1:0];
            b_ocol_reg  <= pos.col[bag_pkg::OCOL_W-1:0];
            b_orow_reg  <= pos.row[bag_pkg::OROW_W-1:0];
            b_val_reg   <= val;
        end
        if (b_valid_reg)
        begin
            w_idx_reg <= b_idx_reg;
            w_sum_reg <= s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            w_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= take;
            w_valid_reg <= b_valid_reg;
        end
    end

    assign cell_valid          = b_valid_reg && b_last_reg;
    assign fin_cell.sum        = s;
    assign fin_cell.column     = b_ocol_reg;
    assign fin_cell.row        = b_orow_reg;
    assign fin_cell.frame_done = b_fdone_reg;

    // input must hold off while a finished cell is handed on
    `BAG_ASSERT_NEXT(a_cell_spacing, cell_valid, !cell_valid, "finished cells back to back")

endmodule

// ===== rtl/bag_level.sv =====
// Brightness level unit: reciprocal multiply, short divide, glyph lookup.
`include "block_average_to_glyph_macros.svh"

module bag_level (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  bag_pkg::cell_t               fin_cell,
    input  logic [bag_pkg::CW_W-1:0]     cw,
    input  logic [bag_pkg::CW_W-1:0]     ch,
    output logic                         busy,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bag_pkg::OCOL_W-1:0]   out_column,
    output logic [bag_pkg::OROW_W-1:0]   out_row,
    output logic [bag_pkg::LVL_W-1:0]    out_level,
    output logic [bag_pkg::CODE_W-1:0]   out_code,
    output logic                         out_frame_done
);

    localparam int SW = bag_pkg::SUM_W;
    localparam int AW = bag_pkg::AREA_W;
    localparam int TW = bag_pkg::T_W;
    localparam int PW = bag_pkg::PROD_W;
    localparam int LW = bag_pkg::LVL_W;

    typedef enum logic [2:0] {L_IDLE, L_MUL, L_SAT, L_DIV, L_DONE} lstate_t;

    lstate_t                     state_reg;
    bag_pkg::cell_t              info_reg;
    logic [AW-1:0]               area_reg;
    logic [PW-1:0]               prod_reg;
    logic [TW-1:0]               rem_reg;
    logic [LW-1:0]               lvl_reg;
    logic [1:0]                  bit_reg;
    logic                        out_valid_reg;
    logic [bag_pkg::OCOL_W-1:0]  out_column_reg;
    logic [bag_pkg::OROW_W-1:0]  out_row_reg;
    logic [LW-1:0]               out_level_reg;
    logic [bag_pkg::CODE_W-1:0]  out_code_reg;
    logic                        out_fdone_reg;

    logic [2*bag_pkg::CW_W-1:0]  area_full;
    logic [PW-1:0]               prod_next;
    logic [TW-1:0]               t;
    logic [TW-1:0]               sat_lim;
    logic [TW-1:0]               cmp;
    logic                        slot_free;

    always_comb
    begin
        area_full = cw * ch;
        prod_next = {info_reg.sum, 1'b0} * bag_pkg::RECIP_M;
        t         = prod_reg[bag_pkg::RECIP_SHIFT +: TW];
        sat_lim   = {area_reg, 4'b0000};
        cmp       = TW'(area_reg) << bit_reg;
        slot_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= L_IDLE;
            out_valid_reg  <= 1'b0;
            info_reg       <= '0;
            area_reg       <= '0;
            prod_reg       <= '0;
            rem_reg        <= '0;
            lvl_reg        <= '0;
            bit_reg        <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
            out_level_reg  <= '0;
            out_code_reg   <= '0;
            out_fdone_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == L_DONE) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        info_reg  <= fin_cell;
                        area_reg  <= area_full[AW-1:0];
                        state_reg <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    // 2*sum/85 through the reciprocal
                    prod_reg  <= prod_next;
                    state_reg <= L_SAT;
                end
                L_SAT:
                begin
                    rem_reg <= t;
                    bit_reg <= 2'd3;
                    if (t >= sat_lim)
                    begin
                        lvl_reg   <= bag_pkg::LEVEL_MAX;
                        state_reg <= L_DONE;
                    end
                    else
                    begin
                        lvl_reg   <= '0;
                        state_reg <= L_DIV;
                    end
                end
                L_DIV:
                begin
                    if (rem_reg >= cmp)
                    begin
                        rem_reg                  <= rem_reg - cmp;
                        lvl_reg[{1'b0, bit_reg}] <= 1'b1;
                    end
                    bit_reg <= bit_reg - 2'd1;
                    if (bit_reg == 2'd0)
                    begin
                        state_reg <= L_DONE;
                    end
                end
                L_DONE:
                begin
                    // hold until the output register is free
                    if (slot_free)
                    begin
                        out_column_reg <= info_reg.column;
                        out_row_reg    <= info_reg.row;
                        out_level_reg  <= lvl_reg;
                        out_code_reg   <= bag_pkg::glyph_code(lvl_reg);
                        out_fdone_reg  <= info_reg.frame_done;
                        state_reg      <= L_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign busy           = state_reg != L_IDLE;
    assign out_valid      = out_valid_reg;
    assign out_column     = out_column_reg;
    assign out_row        = out_row_reg;
    assign out_level      = out_level_reg;
    assign out_code       = out_code_reg;
    assign out_frame_done = out_fdone_reg;

    `BAG_ASSERT_SAME(a_start_idle, start, state_reg == L_IDLE, "cell arrived while busy")
    `BAG_ASSERT_SAME(a_level_range, out_valid_reg, out_level_reg <= 5'd16, "level too high")

endmodule

// ===== test/block_average_to_glyph_test.sv =====
// Self-checking testbench for block_average_to_glyph: pixel stream in, glyph cells out.
module block_average_to_glyph_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS      = bag_pkg::COLUMNS_DEF;
    localparam int ROWS         = bag_pkg::ROWS_DEF;
    localparam int ITEM_TARGET  = 1050;
    localparam int DRAIN_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam logic [8*17-1:0] GLYPH_RAMP = " .:!/r(l1Z4H9W8$@";

    typedef struct packed {
        logic [bag_pkg::OCOL_W-1:0] column;
        logic [bag_pkg::OROW_W-1:0] row;
        logic [bag_pkg::LVL_W-1:0]  level;
        logic [bag_pkg::CODE_W-1:0] code;
        logic                       done;
    } glyph_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [bag_pkg::DATA_W-1:0] s_tdata;
    logic                       s_tuser;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [bag_pkg::DATA_W-1:0] m_tdata;
    logic                       m_tlast;
    logic                       cfg_valid;
    logic                       cfg_ready;
    bag_pkg::cfg_reg_t          cfg_index;
    logic [bag_pkg::CFG_W-1:0]  cfg_data;

    // Predictor state
    logic [bag_pkg::SUM_W-1:0] cell_sums [COLUMNS];
    logic [bag_pkg::PIX_W-1:0] pix_col = '0;
    logic [bag_pkg::PIX_W-1:0] pix_row = '0;
    logic [bag_pkg::CW_W-1:0]  cell_w_reg = bag_pkg::CELL_W_RST;
    logic [bag_pkg::CW_W-1:0]  cell_h_reg = bag_pkg::CELL_H_RST;
    logic [bag_pkg::IW_W-1:0]  image_w_reg = bag_pkg::IMG_W_RST;

    glyph_t expected_glyphs [$];
    int     failures = 0;
    int     pixels_sent = 0;
    bit     tx_steady = 1'b0;
    bit     rx_steady = 1'b0;
    int     rx_stall_left = 0;
    longint cycle_count = 0;

    block_average_to_glyph #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic int unsigned limit_size(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_channel(input int mode, input int base);
        int v;
        if (mode == 0)
            return 8'($urandom_range(0, 255));
        if (mode == 2)
            return $urandom_range(0, 1) ? 8'hff : 8'h00;
        v = base + int'($urandom_range(0, 40)) - 20;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    task automatic predict_glyph(input logic [7:0] red, green, blue, input logic frame_start);
        int unsigned               cw;
        int unsigned               ch;
        int unsigned               iw;
        int unsigned               x;
        int unsigned               y;
        int unsigned               col;
        int unsigned               row;
        int unsigned               last_col;
        logic [bag_pkg::VAL_W-1:0] pix_value;
        logic [bag_pkg::SUM_W-1:0] sum;
        longint unsigned           wide_sum;
        longint unsigned           level;
        glyph_t                    exp_glyph;
        cw = limit_size(cell_w_reg, 64);
        ch = limit_size(cell_h_reg, 64);
        iw = limit_size(image_w_reg, 4096);
        if (frame_start)
        begin
            pix_col = '0;
            pix_row = '0;
        end
        x = pix_col;
        y = pix_row;
        col = x / cw;
        row = y / ch;
        pix_value = {2'b00, red} + green + blue;
        if (col < COLUMNS && row < ROWS)
        begin
            // top-left pixel of a cell restarts the column sum
            if (x % cw == 0 && y % ch == 0)
                sum = pix_value;
            else
                sum = cell_sums[col] + pix_value;
            cell_sums[col] = sum;
            if (x % cw == cw - 1 && y % ch == ch - 1)
            begin
                wide_sum = sum;
                level = (wide_sum * 18 / 765) / (cw * ch);
                if (level > 16)
                    level = 16;
                last_col = iw / cw;
                if (last_col > COLUMNS)
                    last_col = COLUMNS;
                exp_glyph.column = bag_pkg::OCOL_W'(col);
                exp_glyph.row    = bag_pkg::OROW_W'(row);
                exp_glyph.level  = bag_pkg::LVL_W'(level);
                exp_glyph.code   = GLYPH_RAMP[8 * (16 - int'(level)) +: bag_pkg::CODE_W];
                exp_glyph.done   = (row == ROWS - 1) && (last_col != 0) &&
                                   (col == last_col - 1);
                expected_glyphs.push_back(exp_glyph);
            end
        end
        if (x + 1 >= iw)
        begin
            pix_col = '0;
            pix_row = bag_pkg::PIX_W'(y + 1);
        end
        else
            pix_col = bag_pkg::PIX_W'(x + 1);
    endtask

    task automatic send_pixel(input logic [7:0] red, green, blue, input logic frame_start);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        s_tuser  <= frame_start;
        do @(posedge clk); while (!s_tready);
        pixels_sent++;
        predict_glyph(red, green, blue, frame_start);
    endtask

    // Drop valid, drain every expected cell, then let the level unit settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_glyphs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input bag_pkg::cfg_reg_t idx,
                             input logic [bag_pkg::CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        unique case (idx)
            bag_pkg::REG_CELL_WIDTH:  cell_w_reg  = value[bag_pkg::CW_W-1:0];
            bag_pkg::REG_CELL_HEIGHT: cell_h_reg  = value[bag_pkg::CW_W-1:0];
            bag_pkg::REG_IMAGE_WIDTH: image_w_reg = value[bag_pkg::IW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int cw, input int ch, input int iw);
        wait_idle();
        write_reg(bag_pkg::REG_CELL_WIDTH, bag_pkg::CFG_W'(cw));
        write_reg(bag_pkg::REG_CELL_HEIGHT, bag_pkg::CFG_W'(ch));
        write_reg(bag_pkg::REG_IMAGE_WIDTH, bag_pkg::CFG_W'(iw));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_run(input int count, input int mode);
        int base;
        base = $urandom_range(0, 255);
        for (int i = 0; i < count; i++)
            send_pixel(pick_channel(mode, base), pick_channel(mode, base),
                       pick_channel(mode, base), i == 0);
    endtask

    // One pixel per cell, stepping through every level and past saturation
    task automatic test_glyph_levels();
        int val;
        int red;
        int green;
        configure(1, 1, 2);
        for (int k = 0; k <= 18; k++)
        begin
            val = (85 * k + 1) / 2;
            red = (val > 255) ? 255 : val;
            green = (val - red > 255) ? 255 : val - red;
            send_pixel(8'(red), 8'(green), 8'(val - red - green), k == 0);
        end
    endtask

    task automatic test_size_limits();
        configure(0, 0, 0);
        send_random_run(4, 0);
        configure(127, 0, 8191);
        send_random_run(70, 1);
        configure(0, 127, 1);
        send_random_run(66, 2);
        configure(64, 1, 64);
        send_random_run(130, 2);
    endtask

    // Cells cut by the right edge, and a line wider than the grid
    task automatic test_right_edge();
        configure(3, 2, 8);
        send_random_run(35, 0);
        configure(1, 1, 122);
        send_random_run(250, 1);
    endtask

    task automatic run_random_phase();
        int r;
        int sel;
        int cw;
        int ch;
        int iw;
        int full;
        int len;
        int mode;
        int base;
        int n_frames;
        bit fs_first;
        r = $urandom_range(0, 9);
        if (r <= 6)
        begin
            cw = $urandom_range(1, 4);
            ch = $urandom_range(1, 2);
            iw = $urandom_range(1, 6);
        end
        else if (r == 7)
        begin
            cw = $urandom_range(1, 16);
            ch = $urandom_range(1, 8);
            iw = $urandom_range(1, 64);
        end
        else if (r == 8)
        begin
            sel = $urandom_range(0, 3);
            cw = (sel == 0) ? 0 : (sel == 1) ? 64 : (sel == 2) ? 127 : $urandom_range(0, 8191);
            sel = $urandom_range(0, 3);
            ch = (sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 64 : $urandom_range(0, 8191);
            sel = $urandom_range(0, 4);
            iw = (sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 4096 :
                 (sel == 3) ? 8191 : $urandom_range(0, 8191);
        end
        else
        begin
            cw = 1;
            ch = $urandom_range(1, 2);
            iw = $urandom_range(100, 140);
        end
        configure(cw, ch, iw);
        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady = ($urandom_range(0, 4) == 0);
        full = limit_size(image_w_reg, 4096) * limit_size(cell_h_reg, 64) * ROWS;
        n_frames = $urandom_range(1, 3);
        for (int f = 0; f < n_frames; f++)
        begin
            // now and then carry on from the previous position without a frame start
            fs_first = (f == 0) || ($urandom_range(0, 9) != 0);
            if (full <= 400)
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, full)
                                                  : full + $urandom_range(0, 4);
            else
                len = $urandom_range(1, 300);
            mode = $urandom_range(0, 2);
            base = $urandom_range(0, 255);
            for (int i = 0; i < len && pixels_sent < ITEM_TARGET; i++)
                send_pixel(pick_channel(mode, base), pick_channel(mode, base),
                           pick_channel(mode, base),
                           (i == 0 && fs_first) || ($urandom_range(0, 199) == 0));
        end
    endtask

    task automatic test_random_frames();
        while (pixels_sent < ITEM_TARGET)
            run_random_phase();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic check_glyph();
        glyph_t exp_glyph;
        if (expected_glyphs.size() == 0)
        begin
            $error("unexpected cell: column %0d row %0d", m_tdata[6:0], m_tdata[11:7]);
            failures++;
        end
        else
        begin
            exp_glyph = expected_glyphs.pop_front();
            if (m_tdata[6:0] !== exp_glyph.column)
            begin
                $error("cell_column expected %0d got %0d", exp_glyph.column, m_tdata[6:0]);
                failures++;
            end
            if (m_tdata[11:7] !== exp_glyph.row)
            begin
                $error("cell_row expected %0d got %0d", exp_glyph.row, m_tdata[11:7]);
                failures++;
            end
            if (m_tdata[16:12] !== exp_glyph.level)
            begin
                $error("glyph_index expected %0d got %0d", exp_glyph.level, m_tdata[16:12]);
                failures++;
            end
            if (m_tdata[23:17] !== exp_glyph.code)
            begin
                $error("glyph_code expected %0d got %0d", exp_glyph.code, m_tdata[23:17]);
                failures++;
            end
            if (m_tlast !== exp_glyph.done)
            begin
                $error("frame_done expected %0d got %0d", exp_glyph.done, m_tlast);
                failures++;
            end
        end
    endtask

    // Output side: check each transaction, stall at random
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_glyph();
            if (rx_stall_left > 0)
            begin
                m_tready <= 1'b0;
                rx_stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_steady)
                    rx_stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        foreach (cell_sums[i])
            cell_sums[i] = '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= bag_pkg::REG_CELL_WIDTH;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_glyph_levels();
        test_size_limits();
        test_right_edge();
        test_random_frames();
        wait_idle();
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
